// ===== rtl/scatter_gather_segment_splitter_unit_macros.svh =====
// Assertion macros for the scatter-gather segment splitter.
// Included by the modules that carry assertions; expects clk and rst_n in scope.
`ifndef SCATTER_GATHER_SEGMENT_SPLITTER_UNIT_MACROS_SVH
`define SCATTER_GATHER_SEGMENT_SPLITTER_UNIT_MACROS_SVH

// checked only out of reset
`define SGS_ASSERT(lbl, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// checked at every edge, reset included
`define SGS_ASSERT_ALWAYS(lbl, prop, msg) \
    lbl: assert property (@(posedge clk) (prop)) else $error(msg);

`endif

// ===== rtl/sgs_pkg.sv =====
// Shared types and constants for the scatter-gather segment splitter.
// No dependencies; used by every other file of the block but the macros header.
package sgs_pkg;

    localparam int NUM_ENTRIES_DEF = 16;
    localparam int ADDR_BITS_DEF   = 48;

    localparam int IDX_W   = 4;
    localparam int ADDR_W  = 48;
    localparam int SIZE_W  = 32;
    localparam int QUEUE_DEPTH = 2;

    typedef logic [IDX_W-1:0]  idx_t;
    typedef logic [ADDR_W-1:0] addr_t;
    typedef logic [SIZE_W-1:0] size_t;

    // command word passed from the front end to the back end
    typedef struct packed {
        logic  is_xfer;
        idx_t  entry_index;
        addr_t entry_addr;
        size_t entry_size;
        size_t byte_offset;
        size_t byte_length;
    } cmd_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_SKIP,
        ST_FIND,
        ST_EMIT,
        ST_ERR
    } state_t;

endpackage

// ===== rtl/sgs_req_if.sv =====
// Input channel: one beat is a table write or a transfer request.
// Depends on sgs_pkg for field widths.
interface sgs_req_if;
    logic               valid;
    logic               ready;
    logic               cmd;
    sgs_pkg::idx_t      entry_index;
    sgs_pkg::addr_t     entry_addr;
    sgs_pkg::size_t     entry_size;
    sgs_pkg::size_t     byte_offset;
    sgs_pkg::size_t     byte_length;

    modport source (output valid, cmd, entry_index, entry_addr, entry_size,
                    byte_offset, byte_length, input ready);
    modport sink (input valid, cmd, entry_index, entry_addr, entry_size,
                  byte_offset, byte_length, output ready);
endinterface

// ===== rtl/sgs_desc_if.sv =====
// Output channel: one beat is one segment descriptor or an error result.
// Depends on sgs_pkg for field widths.
interface sgs_desc_if;
    logic               valid;
    logic               ready;
    sgs_pkg::addr_t     seg_addr;
    sgs_pkg::size_t     seg_len;
    logic               last;
    logic               status;

    modport source (output valid, seg_addr, seg_len, last, status, input ready);
    modport sink (input valid, seg_addr, seg_len, last, status, output ready);
endinterface

// ===== rtl/sgs_front.sv =====
// Front end: accepts request beats, drops out-of-range table writes and
// queues the rest for the back end. Depends on sgs_pkg and sgs_req_if.
`include "scatter_gather_segment_splitter_unit_macros.svh"

module sgs_front #(
    parameter int NUM_ENTRIES = sgs_pkg::NUM_ENTRIES_DEF
) (
    input  logic            clk,
    input  logic            rst_n,
    sgs_req_if.sink         req,
    output logic            q_valid,
    output sgs_pkg::cmd_t   q_data,
    input  logic            q_pop
);

    localparam int PTR_W = (sgs_pkg::QUEUE_DEPTH > 1) ? $clog2(sgs_pkg::QUEUE_DEPTH) : 1;
    localparam int CNT_W = $clog2(sgs_pkg::QUEUE_DEPTH + 1);

    typedef logic [PTR_W-1:0] ptr_t;
    typedef logic [CNT_W-1:0] cnt_t;

    sgs_pkg::cmd_t q_mem [sgs_pkg::QUEUE_DEPTH];
    ptr_t          wr_ptr_reg, wr_ptr_next;
    ptr_t          rd_ptr_reg, rd_ptr_next;
    cnt_t          count_reg, count_next;

    logic          accept;
    logic          keep;
    logic          push;
    sgs_pkg::cmd_t cmd_in;

    assign req.ready = (count_reg != cnt_t'(sgs_pkg::QUEUE_DEPTH));
    assign accept    = req.valid && req.ready;
    assign keep      = req.cmd || (int'(req.entry_index) < NUM_ENTRIES);
    assign push      = accept && keep;

    assign cmd_in.is_xfer     = req.cmd;
    assign cmd_in.entry_index = req.entry_index;
    assign cmd_in.entry_addr  = req.entry_addr;
    assign cmd_in.entry_size  = req.entry_size;
    assign cmd_in.byte_offset = req.byte_offset;
    assign cmd_in.byte_length = req.byte_length;

    assign q_valid = (count_reg != '0);
    assign q_data  = q_mem[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push)
        begin
            wr_ptr_next = (int'(wr_ptr_reg) == sgs_pkg::QUEUE_DEPTH - 1) ? '0
                                                                         : wr_ptr_reg + ptr_t'(1);
        end
        if (q_pop)
        begin
            rd_ptr_next = (int'(rd_ptr_reg) == sgs_pkg::QUEUE_DEPTH - 1) ? '0
                                                                         : rd_ptr_reg + ptr_t'(1);
        end
        if (push && !q_pop)
        begin
            count_next = count_reg + cnt_t'(1);
        end
        else if (q_pop && !push)
        begin
            count_next = count_reg - cnt_t'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            q_mem[wr_ptr_reg] <= cmd_in;
        end
    end

    `SGS_ASSERT_ALWAYS(a_queue_bound, count_reg <= cnt_t'(sgs_pkg::QUEUE_DEPTH), "queue overfilled")
    `SGS_ASSERT(a_drop_write, (accept && !keep && !q_pop) |=> (count_reg == $past(count_reg)), "out-of-range write was queued")

endmodule

// ===== rtl/sgs_back.sv =====
// Back end: segment table, table walk and descriptor output register.
// Depends on sgs_pkg and sgs_desc_if.
`include "scatter_gather_segment_splitter_unit_macros.svh"

module sgs_back #(
    parameter int NUM_ENTRIES = sgs_pkg::NUM_ENTRIES_DEF,
    parameter int ADDR_BITS   = sgs_pkg::ADDR_BITS_DEF
) (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            cfg_we,
    input  sgs_pkg::idx_t   cfg_wdata,
    input  logic            q_valid,
    input  sgs_pkg::cmd_t   q_data,
    output logic            q_pop,
    sgs_desc_if.source      desc
);

    localparam int IW = (NUM_ENTRIES > 1) ? $clog2(NUM_ENTRIES) : 1;

    typedef logic [IW-1:0]        tidx_t;
    typedef logic [ADDR_BITS-1:0] taddr_t;

    taddr_t          addr_mem [NUM_ENTRIES];
    sgs_pkg::size_t  size_mem [NUM_ENTRIES];
    taddr_t          ent_addr_reg;
    sgs_pkg::size_t  ent_size_reg;

    sgs_pkg::idx_t   cfg_reg;
    tidx_t           lim;

    sgs_pkg::state_t state_reg, state_next;
    tidx_t           idx_reg, idx_next;
    tidx_t           start_reg, start_next;
    tidx_t           end_reg, end_next;
    sgs_pkg::size_t  off_reg, off_next;
    sgs_pkg::size_t  rem_reg, rem_next;
    sgs_pkg::size_t  len_reg, len_next;
    logic            first_reg, first_next;

    logic            out_valid_reg;
    sgs_pkg::addr_t  out_addr_reg;
    sgs_pkg::size_t  out_len_reg;
    logic            out_last_reg;
    logic            out_status_reg;

    logic            can_load;
    logic            ld;
    sgs_pkg::addr_t  ld_addr;
    sgs_pkg::size_t  ld_len;
    logic            ld_last;
    logic            ld_status;
    logic            mem_we;
    sgs_pkg::size_t  avail;
    taddr_t          base_addr;

    assign lim = (int'(cfg_reg) >= NUM_ENTRIES) ? tidx_t'(NUM_ENTRIES - 1) : tidx_t'(cfg_reg);

    assign can_load  = !out_valid_reg || desc.ready;
    assign avail     = first_reg ? (ent_size_reg - off_reg) : ent_size_reg;
    assign base_addr = first_reg ? (ent_addr_reg + taddr_t'(off_reg)) : ent_addr_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg <= '0;
        end
        else if (cfg_we)
        begin
            cfg_reg <= cfg_wdata;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        idx_next   = idx_reg;
        start_next = start_reg;
        end_next   = end_reg;
        off_next   = off_reg;
        rem_next   = rem_reg;
        len_next   = len_reg;
        first_next = first_reg;
        q_pop      = 1'b0;
        mem_we     = 1'b0;
        ld         = 1'b0;
        ld_addr    = '0;
        ld_len     = '0;
        ld_last    = 1'b0;
        ld_status  = 1'b0;
        unique case (state_reg)
            sgs_pkg::ST_IDLE:
            begin
                if (q_valid)
                begin
                    q_pop = 1'b1;
                    if (!q_data.is_xfer)
                    begin
                        mem_we = 1'b1;
                    end
                    else
                    begin
                        off_next   = q_data.byte_offset;
                        len_next   = q_data.byte_length;
                        rem_next   = q_data.byte_length;
                        idx_next   = '0;
                        first_next = 1'b1;
                        state_next = sgs_pkg::ST_SKIP;
                    end
                end
            end
            sgs_pkg::ST_SKIP:
            begin
                if (off_reg != '0 && off_reg >= ent_size_reg)
                begin
                    off_next = off_reg - ent_size_reg;
                    if (idx_reg == lim)
                    begin
                        state_next = sgs_pkg::ST_ERR;
                    end
                    else
                    begin
                        idx_next = idx_reg + tidx_t'(1);
                    end
                end
                else
                begin
                    start_next = idx_reg;
                    state_next = sgs_pkg::ST_FIND;
                end
            end
            sgs_pkg::ST_FIND:
            begin
                if (avail >= rem_reg)
                begin
                    end_next   = idx_reg;
                    idx_next   = start_reg;
                    rem_next   = len_reg;
                    first_next = 1'b1;
                    state_next = sgs_pkg::ST_EMIT;
                end
                else
                begin
                    rem_next   = rem_reg - avail;
                    first_next = 1'b0;
                    if (idx_reg == lim)
                    begin
                        state_next = sgs_pkg::ST_ERR;
                    end
                    else
                    begin
                        idx_next = idx_reg + tidx_t'(1);
                    end
                end
            end
            sgs_pkg::ST_EMIT:
            begin
                if (can_load)
                begin
                    ld      = 1'b1;
                    ld_addr = sgs_pkg::addr_t'(base_addr);
                    if (idx_reg == end_reg)
                    begin
                        ld_len     = rem_reg;
                        ld_last    = 1'b1;
                        state_next = sgs_pkg::ST_IDLE;
                    end
                    else
                    begin
                        ld_len     = avail;
                        rem_next   = rem_reg - avail;
                        first_next = 1'b0;
                        idx_next   = idx_reg + tidx_t'(1);
                    end
                end
            end
            sgs_pkg::ST_ERR:
            begin
                if (can_load)
                begin
                    ld         = 1'b1;
                    ld_last    = 1'b1;
                    ld_status  = 1'b1;
                    state_next = sgs_pkg::ST_IDLE;
                end
            end
            default:
            begin
                state_next = sgs_pkg::ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= sgs_pkg::ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_ff @(posedge clk)
    begin
        idx_reg   <= idx_next;
        start_reg <= start_next;
        end_reg   <= end_next;
        off_reg   <= off_next;
        rem_reg   <= rem_next;
        len_reg   <= len_next;
        first_reg <= first_next;
    end

    // table: read address is idx_next, so the registered data lines up with idx_reg
    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            addr_mem[tidx_t'(q_data.entry_index)] <= taddr_t'(q_data.entry_addr);
            size_mem[tidx_t'(q_data.entry_index)] <= q_data.entry_size;
        end
        ent_addr_reg <= addr_mem[idx_next];
        ent_size_reg <= size_mem[idx_next];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (ld)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (desc.ready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (ld)
        begin
            out_addr_reg   <= ld_addr;
            out_len_reg    <= ld_len;
            out_last_reg   <= ld_last;
            out_status_reg <= ld_status;
        end
    end

    assign desc.valid    = out_valid_reg;
    assign desc.seg_addr = out_addr_reg;
    assign desc.seg_len  = out_len_reg;
    assign desc.last     = out_last_reg;
    assign desc.status   = out_status_reg;

    `SGS_ASSERT(a_emit_range, (state_reg == sgs_pkg::ST_EMIT) |-> (idx_reg <= end_reg), "emit walked past end segment")
    `SGS_ASSERT(a_walk_lim, (state_reg == sgs_pkg::ST_SKIP || state_reg == sgs_pkg::ST_FIND) |-> (idx_reg <= lim), "walk beyond last entry")
    `SGS_ASSERT(a_last_idle, (ld && ld_last) |=> (state_reg == sgs_pkg::ST_IDLE), "final beat did not end transfer")
    `SGS_ASSERT(a_err_beat, (out_valid_reg && out_status_reg) |-> (out_addr_reg == '0 && out_len_reg == '0 && out_last_reg), "malformed error beat")

endmodule

// ===== rtl/scatter_gather_segment_splitter_unit.sv =====
// Scatter-gather segment splitter, top level.
// Request beats (req) carry table writes or transfer requests; descriptor
// beats (desc) carry one segment each. valid/ready on both, beat on both high.
// cfg_we/cfg_wdata load last_entry_index; write only while idle.
// A table write gives no beat. A transfer skips s entries by the offset,
// scans f entries to find the end segment and emits d descriptors. The single
// table read port is walked one entry a cycle while the descriptor output is
// not stalled. A two-beat queue lets requests be taken while a transfer runs.
// An offset or length beyond the table gives one beat with status 1, last 1.
// Reset clears the queue, the walk state machine, the output valid flag and
// last_entry_index; table contents are undefined until written.
// A stalled receiver holds the descriptor register; emission waits behind it.
// Depends on sgs_pkg, sgs_req_if, sgs_desc_if, sgs_front and sgs_back.
module scatter_gather_segment_splitter_unit #(
    parameter int NUM_ENTRIES = sgs_pkg::NUM_ENTRIES_DEF,
    parameter int ADDR_BITS   = sgs_pkg::ADDR_BITS_DEF
) (
    input  logic            clk,
    input  logic            rst_n,
    sgs_req_if.sink         req,
    sgs_desc_if.source      desc,
    input  logic            cfg_we,
    input  sgs_pkg::idx_t   cfg_wdata
);

    logic          q_valid;
    logic          q_pop;
    sgs_pkg::cmd_t q_data;

    sgs_front #(
        .NUM_ENTRIES (NUM_ENTRIES)
    ) u_front (
        .clk     (clk),
        .rst_n   (rst_n),
        .req     (req),
        .q_valid (q_valid),
        .q_data  (q_data),
        .q_pop   (q_pop)
    );

    sgs_back #(
        .NUM_ENTRIES (NUM_ENTRIES),
        .ADDR_BITS   (ADDR_BITS)
    ) u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_wdata (cfg_wdata),
        .q_valid   (q_valid),
        .q_data    (q_data),
        .q_pop     (q_pop),
        .desc      (desc)
    );

endmodule
